// ===== rtl/soa_pkg.sv =====
package soa_pkg;

  localparam int ADDR_W = 48;
  localparam int STRIDE_W = 17;
  localparam int BYTES_W = 16;
  localparam int ALIGN_W = 13;
  localparam int KIND_W = 2;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_SLABS = 16;
  localparam int DEF_MAX_OBJECTS = 512;
  localparam int DEF_MIN_BLOCK_BYTES = 4096;
  localparam int DEF_SLAB_ORDER = 0;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_ALIGN = 2'd1;

  localparam logic [BYTES_W-1:0] RESET_BYTES = 16'd64;
  localparam logic [ALIGN_W-1:0] RESET_ALIGN = 13'd8;
  localparam logic [STRIDE_W-1:0] RESET_STRIDE = 17'd64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_SCAN,
    S_A_POP,
    S_A_ADD,
    S_A_DIV,
    S_A_FILL,
    S_F_SCAN,
    S_F_DIV,
    S_F_CHK,
    S_D_EMIT
  } state_t;

  typedef struct packed {
    logic ok;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

endpackage

// ===== rtl/soa_ram.sv =====
module soa_ram import soa_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/soa_div.sv =====
module soa_div import soa_pkg::*; #(
  parameter int DIV_W = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_W-1:0]    dividend,
  input  logic [STRIDE_W-1:0] divisor,
  output logic                done,
  output logic [DIV_W-1:0]    quotient,
  output logic [STRIDE_W-1:0] remainder
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0] cnt;
  logic run;
  logic [STRIDE_W:0] trial;
  logic fit;

  assign trial = {remainder, quotient[DIV_W-1]};
  assign fit = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(DIV_W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit a cycle, restoring
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
    end else if (run) begin
      quotient <= {quotient[DIV_W-2:0], fit};
      remainder <= fit ? STRIDE_W'(trial - {1'b0, divisor}) : trial[STRIDE_W-1:0];
    end
  end

endmodule

// ===== rtl/slab_object_allocator_unit.sv =====
// Slab object allocator. An item is taken when start is high and busy is low; each result
// is a one-cycle pulse on done and must be captured then, since the receiver cannot stall.
// Allocate from an existing slab scans the slabs in order until one has a free object, then
// pops an object from it. Adding a slab runs the capacity division and the fill of the free
// stack and taken memories, one entry per object, in place of the pop (DIV_W is 13 for the
// default block size). Free passes over each slab whose block does not hold the address and
// runs the bit-serial stride divider on each that does, then checks the taken bit and gives
// the result. Destroy gives one result per cycle, one per slab, or one result with no slabs.
// A disabled block or an unknown kind answers on the cycle after the item is taken.
module slab_object_allocator_unit import soa_pkg::*; #(
  parameter int MAX_SLABS = DEF_MAX_SLABS,
  parameter int MAX_OBJECTS = DEF_MAX_OBJECTS,
  parameter int MIN_BLOCK_BYTES = DEF_MIN_BLOCK_BYTES,
  parameter int SLAB_ORDER = DEF_SLAB_ORDER
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    kind,
  input  logic [ADDR_W-1:0]    object_address,
  input  logic [ADDR_W-1:0]    grant_base,
  input  logic                 grant_ok,
  output logic                 done,
  output logic                 status,
  output logic [ADDR_W-1:0]    result_address,
  output logic                 release_block,
  output logic                 grant_taken,
  output logic                 last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data
);

  localparam int BLOCK_BYTES = MIN_BLOCK_BYTES << SLAB_ORDER;
  localparam int DIV_W = $clog2(BLOCK_BYTES + 1);
  localparam int SLAB_W = (MAX_SLABS > 1) ? $clog2(MAX_SLABS) : 1;
  localparam int SLOT_W = $clog2(MAX_SLABS + 1);
  localparam int OBJ_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
  localparam int DEPTH = MAX_SLABS * MAX_OBJECTS;
  localparam int MEM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PROD_W = OBJ_W + STRIDE_W;

  state_t st, st_next;

  logic [BYTES_W-1:0] obj_bytes;
  logic [ALIGN_W-1:0] obj_align;
  logic enabled;
  logic [STRIDE_W-1:0] stride;
  logic [SLOT_W-1:0] slabs;
  logic [SLOT_W-1:0] scan, scan_next;
  logic [ADDR_W-1:0] base_tab [MAX_SLABS];
  logic [CNT_W-1:0] cap_tab [MAX_SLABS];
  logic [CNT_W-1:0] ft_tab [MAX_SLABS];

  logic [ADDR_W-1:0] addr_q, grant_q;
  logic gok_q;
  logic [OBJ_W-1:0] idx, idx_next;
  logic [OBJ_W-1:0] fill_k, fill_k_next;
  logic [CNT_W-1:0] fill_cnt;
  logic [PROD_W-1:0] prod, prod_next;

  logic emit, e_status, e_rel, e_taken, e_last;
  logic [ADDR_W-1:0] e_addr;
  logic ft_we;
  logic [CNT_W-1:0] ft_wval;
  logic slab_open, slabs_inc, kill;

  logic stk_we, stk_re, tk_we, tk_re, tk_wdata, tk_rdata;
  logic [MEM_AW-1:0] stk_waddr, stk_raddr, tk_waddr, tk_raddr;
  logic [OBJ_W-1:0] stk_wdata, stk_rdata;

  logic div_start, div_done;
  logic [DIV_W-1:0] div_dividend, div_q;
  logic [STRIDE_W-1:0] div_r;

  logic [SLAB_W-1:0] si, ns;
  logic [ADDR_W-1:0] off;
  logic scan_end;
  cfg_t cfg_new;

  function automatic logic [MEM_AW-1:0] mem_addr(input logic [SLAB_W-1:0] s,
                                                 input logic [OBJ_W-1:0] k);
    mem_addr = MEM_AW'(MEM_AW'(s) * MEM_AW'(MAX_OBJECTS)) + MEM_AW'(k);
  endfunction

  function automatic cfg_t recompute(input logic [BYTES_W-1:0] b,
                                     input logic [ALIGN_W-1:0] a);
    cfg_t c;
    logic [STRIDE_W-1:0] s, am;
    s = (b < BYTES_W'(8)) ? STRIDE_W'(8) : STRIDE_W'(b);
    am = STRIDE_W'(a) - 1'b1;
    c.ok = (b != '0) && (a != '0) && ((a & (a - 1'b1)) == '0) &&
           (32'(a) <= 32'(MIN_BLOCK_BYTES));
    c.stride = c.ok ? ((s + am) & ~am) : '0;
    recompute = c;
  endfunction

  assign busy = (st != S_IDLE);
  assign cfg_ready = 1'b1;
  assign si = scan[SLAB_W-1:0];
  assign ns = slabs[SLAB_W-1:0];
  assign off = addr_q - base_tab[si];
  assign scan_end = (scan == slabs);
  assign cfg_new = recompute(
      (cfg_index == REG_OBJECT_BYTES) ? cfg_data : obj_bytes,
      (cfg_index == REG_OBJECT_ALIGN) ? cfg_data[ALIGN_W-1:0] : obj_align);

  soa_ram #(.WIDTH(OBJ_W), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .wr_en(stk_we), .wr_addr(stk_waddr), .wr_data(stk_wdata),
    .rd_en(stk_re), .rd_addr(stk_raddr), .rd_data(stk_rdata)
  );

  soa_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_taken (
    .clk(clk), .wr_en(tk_we), .wr_addr(tk_waddr), .wr_data(tk_wdata),
    .rd_en(tk_re), .rd_addr(tk_raddr), .rd_data(tk_rdata)
  );

  soa_div #(.DIV_W(DIV_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend), .divisor(stride),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    scan_next = scan;
    idx_next = idx;
    fill_k_next = fill_k;
    prod_next = prod;
    emit = 1'b0;
    e_status = 1'b0;
    e_addr = '0;
    e_rel = 1'b0;
    e_taken = 1'b0;
    e_last = 1'b1;
    ft_we = 1'b0;
    ft_wval = ft_tab[si];
    slab_open = 1'b0;
    slabs_inc = 1'b0;
    kill = 1'b0;
    stk_we = 1'b0;
    stk_waddr = mem_addr(si, '0);
    stk_wdata = '0;
    stk_re = 1'b0;
    stk_raddr = mem_addr(si, OBJ_W'(ft_tab[si] - 1'b1));
    tk_we = 1'b0;
    tk_waddr = mem_addr(si, stk_rdata);
    tk_wdata = 1'b0;
    tk_re = 1'b0;
    tk_raddr = mem_addr(si, div_q[OBJ_W-1:0]);
    div_start = 1'b0;
    div_dividend = DIV_W'(BLOCK_BYTES);
    case (st)
      S_IDLE: begin
        if (start) begin
          scan_next = '0;
          case (kind)
            KIND_ALLOC: begin
              if (enabled) begin
                st_next = S_A_SCAN;
              end else begin
                emit = 1'b1;
                e_status = 1'b1;
              end
            end
            KIND_FREE: begin
              if (enabled) begin
                st_next = S_F_SCAN;
              end else begin
                emit = 1'b1;
                e_status = 1'b1;
              end
            end
            KIND_DESTROY: begin
              if (slabs == '0) begin
                emit = 1'b1;
                kill = 1'b1;
              end else begin
                st_next = S_D_EMIT;
              end
            end
            default: begin
              emit = 1'b1;
              e_status = 1'b1;
            end
          endcase
        end
      end
      S_A_SCAN: begin
        if (scan_end) begin
          if ((32'(slabs) >= 32'(MAX_SLABS)) || !gok_q) begin
            emit = 1'b1;
            e_status = 1'b1;
            st_next = S_IDLE;
          end else begin
            div_start = 1'b1;
            st_next = S_A_DIV;
          end
        end else if (ft_tab[si] != '0) begin
          stk_re = 1'b1;
          st_next = S_A_POP;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      S_A_POP: begin
        tk_we = 1'b1;
        tk_wdata = 1'b1;
        ft_we = 1'b1;
        ft_wval = ft_tab[si] - 1'b1;
        prod_next = PROD_W'(stk_rdata) * PROD_W'(stride);
        st_next = S_A_ADD;
      end
      S_A_ADD: begin
        emit = 1'b1;
        e_addr = base_tab[si] + ADDR_W'(prod);
        st_next = S_IDLE;
      end
      S_A_DIV: begin
        if (div_done) begin
          if ((div_q == '0) || (32'(div_q) > 32'(MAX_OBJECTS))) begin
            // block too small or too big for the stride: hand it back
            emit = 1'b1;
            e_status = 1'b1;
            e_addr = grant_q;
            e_rel = 1'b1;
            e_taken = 1'b1;
            st_next = S_IDLE;
          end else begin
            slab_open = 1'b1;
            fill_k_next = '0;
            st_next = S_A_FILL;
          end
        end
      end
      S_A_FILL: begin
        // stack holds count-1 down to 0; object 0 goes out with this item
        stk_we = 1'b1;
        stk_waddr = mem_addr(ns, fill_k);
        stk_wdata = OBJ_W'(fill_cnt - 1'b1 - CNT_W'(fill_k));
        tk_we = 1'b1;
        tk_waddr = mem_addr(ns, fill_k);
        tk_wdata = (fill_k == '0);
        if (CNT_W'(fill_k) == fill_cnt - 1'b1) begin
          slabs_inc = 1'b1;
          emit = 1'b1;
          e_addr = grant_q;
          e_taken = 1'b1;
          st_next = S_IDLE;
        end else begin
          fill_k_next = fill_k + 1'b1;
        end
      end
      S_F_SCAN: begin
        if (scan_end) begin
          emit = 1'b1;
          e_status = 1'b1;
          st_next = S_IDLE;
        end else if (off >= ADDR_W'(BLOCK_BYTES)) begin
          scan_next = scan + 1'b1;
        end else begin
          div_start = 1'b1;
          div_dividend = off[DIV_W-1:0];
          st_next = S_F_DIV;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          if ((div_r != '0) || (32'(div_q) >= 32'(cap_tab[si])) ||
              (32'(div_q) >= 32'(MAX_OBJECTS))) begin
            scan_next = scan + 1'b1;
            st_next = S_F_SCAN;
          end else begin
            tk_re = 1'b1;
            idx_next = div_q[OBJ_W-1:0];
            st_next = S_F_CHK;
          end
        end
      end
      S_F_CHK: begin
        emit = 1'b1;
        st_next = S_IDLE;
        if (!tk_rdata || (ft_tab[si] >= cap_tab[si])) begin
          e_status = 1'b1;
        end else begin
          stk_we = 1'b1;
          stk_waddr = mem_addr(si, OBJ_W'(ft_tab[si]));
          stk_wdata = idx;
          tk_we = 1'b1;
          tk_waddr = mem_addr(si, idx);
          tk_wdata = 1'b0;
          ft_we = 1'b1;
          ft_wval = ft_tab[si] + 1'b1;
        end
      end
      S_D_EMIT: begin
        emit = 1'b1;
        e_addr = base_tab[si];
        e_rel = 1'b1;
        e_last = (scan + 1'b1 == slabs);
        if (e_last) begin
          kill = 1'b1;
          st_next = S_IDLE;
        end else begin
          scan_next = scan + 1'b1;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obj_bytes <= RESET_BYTES;
      obj_align <= RESET_ALIGN;
      enabled <= 1'b1;
      stride <= RESET_STRIDE;
      slabs <= '0;
      done <= 1'b0;
    end else begin
      done <= emit;
      if (kill) begin
        slabs <= '0;
        enabled <= 1'b0;
        stride <= '0;
      end else begin
        if (cfg_valid && (slabs == '0) &&
            ((cfg_index == REG_OBJECT_BYTES) || (cfg_index == REG_OBJECT_ALIGN))) begin
          if (cfg_index == REG_OBJECT_BYTES) begin
            obj_bytes <= cfg_data;
          end else begin
            obj_align <= cfg_data[ALIGN_W-1:0];
          end
          enabled <= cfg_new.ok;
          stride <= cfg_new.stride;
        end
        if (slabs_inc) begin
          slabs <= slabs + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scan <= scan_next;
    idx <= idx_next;
    fill_k <= fill_k_next;
    prod <= prod_next;
    if (start && !busy) begin
      addr_q <= object_address;
      grant_q <= grant_base;
      gok_q <= grant_ok;
    end
    if (emit) begin
      status <= e_status;
      result_address <= e_addr;
      release_block <= e_rel;
      grant_taken <= e_taken;
      last <= e_last;
    end
    if (ft_we) begin
      ft_tab[si] <= ft_wval;
    end
    if (slab_open) begin
      base_tab[ns] <= grant_q;
      cap_tab[ns] <= div_q[CNT_W-1:0];
      ft_tab[ns] <= div_q[CNT_W-1:0] - 1'b1;
      fill_cnt <= div_q[CNT_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy)
    else $error("destroy result without last while idle");

  a_slab_bound: assert property (@(posedge clk) disable iff (rst)
    32'(slabs) <= 32'(MAX_SLABS))
    else $error("slab count beyond limit");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (st == S_A_DIV || st == S_F_DIV))
    else $error("divider finished with no waiting state");

  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    slabs_inc |=> (slabs == $past(slabs) + 1'b1) && done && grant_taken)
    else $error("slab add did not report the grant");
`endif

endmodule

// ===== sim/alloc_result_checker.sv =====
`timescale 1ns / 100ps

module alloc_result_checker import soa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 busy,
  input  logic [KIND_W-1:0]    kind,
  input  logic [ADDR_W-1:0]    object_address,
  input  logic [ADDR_W-1:0]    grant_base,
  input  logic                 grant_ok,
  input  logic                 done,
  input  logic                 status,
  input  logic [ADDR_W-1:0]    result_address,
  input  logic                 release_block,
  input  logic                 grant_taken,
  input  logic                 last,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTES_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   waiting
);

  localparam int SLABS = DEF_MAX_SLABS;
  localparam int OBJS = DEF_MAX_OBJECTS;
  localparam longint BLOCK = longint'(DEF_MIN_BLOCK_BYTES) << DEF_SLAB_ORDER;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] addr;
    logic              rel;
    logic              taken;
    logic              last;
  } outcome_t;

  outcome_t expected_results[$];

  logic [BYTES_W-1:0]  obj_bytes;
  logic [ALIGN_W-1:0]  obj_align;
  logic                enabled;
  logic [STRIDE_W-1:0] stride;
  int                  slab_count;
  logic [ADDR_W-1:0]   slab_base[SLABS];
  int                  slab_cap[SLABS];
  int                  slab_avail[SLABS];
  int                  free_stack[SLABS*OBJS];
  bit                  in_use[SLABS*OBJS];

  function automatic void derive_stride();
    longint a;
    longint s;
    a = obj_align;
    if (obj_bytes != 0 && a != 0 && (a & (a - 1)) == 0 && a <= DEF_MIN_BLOCK_BYTES) begin
      s = (obj_bytes < 8) ? 8 : obj_bytes;
      stride = STRIDE_W'((s + a - 1) & ~(a - 1));
      enabled = 1'b1;
    end else begin
      stride = '0;
      enabled = 1'b0;
    end
  endfunction

  function automatic void expect_result(logic st, logic [ADDR_W-1:0] addr, logic rel,
                                        logic tk, logic lst);
    outcome_t o;
    o.status = st;
    o.addr = addr;
    o.rel = rel;
    o.taken = tk;
    o.last = lst;
    expected_results.push_back(o);
  endfunction

  function automatic logic [ADDR_W-1:0] pop_object(int s);
    int top;
    int idx;
    top = slab_avail[s] - 1;
    idx = free_stack[s*OBJS + top];
    in_use[s*OBJS + idx] = 1'b1;
    slab_avail[s] = top;
    return slab_base[s] + ADDR_W'(longint'(idx) * stride);
  endfunction

  function automatic void model_allocate(logic [ADDR_W-1:0] gbase, logic gok);
    longint count;
    int s;
    if (!enabled || stride == 0) begin
      expect_result(1'b1, '0, 1'b0, 1'b0, 1'b1);
      return;
    end
    for (s = 0; s < slab_count; s++) begin
      if (slab_avail[s] != 0) begin
        expect_result(1'b0, pop_object(s), 1'b0, 1'b0, 1'b1);
        return;
      end
    end
    if (slab_count >= SLABS || !gok) begin
      expect_result(1'b1, '0, 1'b0, 1'b0, 1'b1);
      return;
    end
    count = BLOCK / stride;
    if (count == 0 || count > OBJS) begin
      // stride does not fit: hand the block straight back
      expect_result(1'b1, gbase, 1'b1, 1'b1, 1'b1);
      return;
    end
    s = slab_count;
    slab_base[s] = gbase;
    slab_cap[s] = int'(count);
    slab_avail[s] = int'(count);
    for (int k = 0; k < count; k++) begin
      free_stack[s*OBJS + k] = int'(count) - 1 - k;
      in_use[s*OBJS + k] = 1'b0;
    end
    slab_count = s + 1;
    expect_result(1'b0, pop_object(s), 1'b0, 1'b1, 1'b1);
  endfunction

  function automatic void model_free(logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] off;
    longint idx;
    if (enabled && stride != 0) begin
      for (int s = 0; s < slab_count; s++) begin
        off = addr - slab_base[s];
        if (off >= BLOCK || off % stride != 0) continue;
        idx = off / stride;
        if (idx >= slab_cap[s] || idx >= OBJS) continue;
        // lowest matching slab decides, even when the free is refused
        if (!in_use[s*OBJS + idx] || slab_avail[s] >= slab_cap[s]) break;
        free_stack[s*OBJS + slab_avail[s]] = int'(idx);
        slab_avail[s]++;
        in_use[s*OBJS + idx] = 1'b0;
        expect_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
        return;
      end
    end
    expect_result(1'b1, '0, 1'b0, 1'b0, 1'b1);
  endfunction

  function automatic void model_destroy();
    if (slab_count == 0) expect_result(1'b0, '0, 1'b0, 1'b0, 1'b1);
    for (int s = 0; s < slab_count; s++)
      expect_result(1'b0, slab_base[s], 1'b1, 1'b0, s + 1 == slab_count);
    slab_count = 0;
    stride = '0;
    enabled = 1'b0;
  endfunction

  outcome_t got;
  outcome_t want;

  always @(posedge clk) begin
    if (rst) begin
      obj_bytes = RESET_BYTES;
      obj_align = RESET_ALIGN;
      derive_stride();
      slab_count = 0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready && slab_count == 0) begin
        if (cfg_index == REG_OBJECT_BYTES) begin
          obj_bytes = cfg_data;
          derive_stride();
        end else if (cfg_index == REG_OBJECT_ALIGN) begin
          obj_align = cfg_data[ALIGN_W-1:0];
          derive_stride();
        end
      end
      if (done) begin
        got = {status, result_address, release_block, grant_taken, last};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: st=%0b addr=%h rel=%0b tk=%0b last=%0b",
                     status, result_address, release_block, grant_taken, last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st=%0b addr=%h rel=%0b tk=%0b last=%0b | got st=%0b addr=%h rel=%0b tk=%0b last=%0b",
                       want.status, want.addr, want.rel, want.taken, want.last,
                       status, result_address, release_block, grant_taken, last);
          end
        end
      end
      if (start && !busy) begin
        case (kind)
          KIND_ALLOC:   model_allocate(grant_base, grant_ok);
          KIND_FREE:    model_free(object_address);
          KIND_DESTROY: model_destroy();
          default:      expect_result(1'b1, '0, 1'b0, 1'b0, 1'b1);
        endcase
      end
    end
    waiting <= expected_results.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb import soa_pkg::*; ;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [ADDR_W-1:0] TOP_PAGE = 48'hFFFF_FFFF_F000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    kind;
  logic [ADDR_W-1:0]    object_address;
  logic [ADDR_W-1:0]    grant_base;
  logic                 grant_ok;
  logic                 done;
  logic                 status;
  logic [ADDR_W-1:0]    result_address;
  logic                 release_block;
  logic                 grant_taken;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTES_W-1:0]   cfg_data;
  int                   mismatches;
  int                   waiting;

  slab_object_allocator_unit u_dut (.*);
  alloc_result_checker u_chk (.*);

  logic [KIND_W-1:0] issued_kinds[$];
  logic [ADDR_W-1:0] live_objects[$];
  logic [ADDR_W-1:0] last_freed;
  logic              idle_on;
  int                item_count;

  logic [15:0] phase_bytes[7] = '{16'd64, 16'd2048, 16'd24, 16'd1, 16'd100, 16'd4097, 16'd65535};
  logic [15:0] phase_align[7] = '{16'd8, 16'd8, 16'd16, 16'd1, 16'd64, 16'd1, 16'd4096};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // track handed-out objects so frees can target them
  always @(posedge clk) begin
    if (!rst && done && issued_kinds.size() != 0) begin
      if (issued_kinds[0] == KIND_ALLOC && !status) live_objects.push_back(result_address);
      if (last) void'(issued_kinds.pop_front());
    end
  end

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  task automatic issue(logic [KIND_W-1:0] k, logic [ADDR_W-1:0] oa,
                       logic [ADDR_W-1:0] gb, logic gok);
    start <= 1'b1;
    kind <= k;
    object_address <= oa;
    grant_base <= gb;
    grant_ok <= gok;
    do @(posedge clk); while (busy);
    issued_kinds.push_back(k);
    item_count++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (waiting != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTES_W-1:0] data);
    settle();
    if (idle_on) repeat ($urandom_range(0, 14)) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic destroy_and_set(logic [15:0] b, logic [15:0] a);
    settle();
    issue(KIND_DESTROY, rand48(), rand48(), 1'($urandom_range(0, 1)));
    live_objects.delete();
    write_reg(REG_OBJECT_BYTES, b);
    write_reg(REG_OBJECT_ALIGN, a);
  endtask

  task automatic random_item(int p);
    int r;
    int j;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      issue(KIND_ALLOC, rand48(), rand48(), $urandom_range(0, 99) < 85);
    end else if (r < 92) begin
      r = $urandom_range(0, 99);
      if (live_objects.size() != 0 && r < 65) begin
        j = $urandom_range(0, live_objects.size() - 1);
        a = live_objects[j];
        live_objects.delete(j);
        last_freed = a;
      end else if (live_objects.size() != 0 && r < 78) begin
        a = live_objects[$urandom_range(0, live_objects.size() - 1)] + $urandom_range(1, 7);
      end else if (r < 86) begin
        a = last_freed;  // double free
      end else begin
        a = rand48();
      end
      issue(KIND_FREE, a, rand48(), 1'($urandom_range(0, 1)));
    end else if (r < 97) begin
      issue(KIND_UNUSED, rand48(), rand48(), 1'($urandom_range(0, 1)));
    end else begin
      destroy_and_set(phase_bytes[p], phase_align[p]);
    end
  endtask

  int  cycles;
  logic timed_out;

  initial begin
    rst = 1'b1;
    start = 1'b0;
    kind = KIND_ALLOC;
    object_address = '0;
    grant_base = '0;
    grant_ok = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_OBJECT_BYTES;
    cfg_data = '0;
    idle_on = 1'b1;
    item_count = 0;
    last_freed = '0;
    timed_out = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty block, disabled block, bad settings
    issue(KIND_ALLOC, TOP_PAGE, TOP_PAGE, 1'b0);
    issue(KIND_FREE, 48'h123, '0, 1'b0);
    issue(KIND_DESTROY, '0, '0, 1'b0);
    issue(KIND_ALLOC, TOP_PAGE, TOP_PAGE, 1'b1);
    issue(KIND_FREE, TOP_PAGE, '0, 1'b0);
    write_reg(REG_OBJECT_BYTES, 16'd0);
    write_reg(REG_OBJECT_ALIGN, 16'd3);
    write_reg(REG_OBJECT_ALIGN, 16'd8192);
    write_reg(REG_SPARE, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h5555);
    write_reg(REG_OBJECT_BYTES, 16'd1);
    write_reg(REG_OBJECT_ALIGN, 16'd1);

    // smallest stride, slab at the top of the address space
    issue(KIND_ALLOC, '0, TOP_PAGE, 1'b1);
    issue(KIND_ALLOC, '0, 48'h0000_1234_5000, 1'b1);
    issue(KIND_ALLOC, '0, 48'h0000_1234_5000, 1'b1);
    issue(KIND_FREE, TOP_PAGE + 48'd8, '0, 1'b0);
    issue(KIND_FREE, TOP_PAGE + 48'd8, '0, 1'b0);
    issue(KIND_FREE, TOP_PAGE + 48'd4, '0, 1'b0);
    issue(KIND_FREE, TOP_PAGE + 48'd4096, '0, 1'b0);
    issue(KIND_UNUSED, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1);
    write_reg(REG_OBJECT_BYTES, 16'd5000);
    issue(KIND_DESTROY, '0, '0, 1'b0);

    // strides too large for a block
    write_reg(REG_OBJECT_BYTES, 16'd4097);
    issue(KIND_ALLOC, '0, 48'h0000_0000_A000, 1'b1);
    write_reg(REG_OBJECT_BYTES, 16'd65535);
    write_reg(REG_OBJECT_ALIGN, 16'd4096);
    issue(KIND_ALLOC, '0, 48'hFFFF_FFFF_FFFF, 1'b1);

    // one object per slab
    write_reg(REG_OBJECT_BYTES, 16'd3000);
    issue(KIND_ALLOC, '0, '0, 1'b1);
    issue(KIND_ALLOC, '0, 48'h0000_0000_1000, 1'b1);
    issue(KIND_FREE, '0, '0, 1'b0);
    settle();
    issue(KIND_DESTROY, '0, '0, 1'b0);
    live_objects.delete();

    for (int p = 0; p < 7; p++) begin
      idle_on = (p < 6);
      destroy_and_set(phase_bytes[p], phase_align[p]);
      for (int i = 0; i < 19; i++) random_item(p);
    end

    start <= 1'b0;
    cycles = 0;
    repeat (2) @(posedge clk);
    while ((waiting != 0 || busy) && cycles < 200000) begin
      @(posedge clk);
      cycles++;
    end
    if (cycles >= 200000) begin
      timed_out = 1'b1;
    end else begin
      repeat (50) @(posedge clk);
    end
    if (timed_out) begin
      $display("Regression FAIL");
    end else begin
      $display("Ran %0d items over 7 allocator settings plus directed cases:", item_count);
      $display("slab growth, hand-back, bad frees, destroy and register writes.");
      if (mismatches == 0 && waiting == 0) begin
        $display("Regression PASS");
      end else begin
        $display("Regression FAIL");
      end
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/soa_pkg.sv
rtl/soa_ram.sv
rtl/soa_div.sv
rtl/slab_object_allocator_unit.sv
sim/alloc_result_checker.sv
sim/tb.sv
